>>> src/als_pkg.sv
`default_nettype none
package als_pkg;

  localparam int VW      = 64;
  localparam int MAX_EXP = 63;
  localparam int FW      = 64;
  localparam int EW      = 6;
  localparam int LW      = $clog2(VW);
  localparam int SW      = ((LW > EW) ? LW : EW) + 3;
  localparam int HW      = (VW + 1) / 2;
  localparam int CW      = $clog2(VW);

  typedef struct packed {
    logic          big;
    logic [VW-1:0] v;
  } sv_t;

  typedef enum logic [2:0] {
    SEL_E1, SEL_A, SEL_B, SEL_C, SEL_D
  } sel_t;

  typedef enum logic [1:0] {
    RES_NONE, RES_E1, RES_MID
  } res_t;

  typedef struct packed {
    logic load;
    logic lg_step;
    logic div_start;
    logic div_store;
    sel_t div_sel;
    logic bounds;
    logic eval_init;
    logic mul_start;
    logic mul_fin;
    logic iter_upd;
    logic sum;
    logic cmp_upd;
    logic finish;
    res_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic is_e1;
    logic e1_ok;
    logic single;
    logic lg_done;
    logic div_busy;
    logic mul_busy;
    logic range_empty;
    logic iter_last;
    logic hit;
    logic stop;
    logic out_busy;
  } sts_t;

  // saturating add, any overflow counts as big
  function automatic sv_t sat_add(input sv_t a, input sv_t b);
    logic [VW:0] t;
    sv_t         r;
    t = {1'b0, a.v} + {1'b0, b.v};
    if (a.big || b.big || t[VW]) begin
      r.big = 1'b1;
      r.v   = '1;
    end else begin
      r.big = 1'b0;
      r.v   = t[VW-1:0];
    end
    return r;
  endfunction

  // 2^l - 1, all ones once l reaches the value width
  function automatic logic [VW-1:0] rfl(input logic [SW-1:0] l);
    logic [VW-1:0] r;
    if (l >= SW'(VW)) begin
      r = '1;
    end else begin
      r = (VW'(1) << l) - VW'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/aliquot_last_base_solver.sv
`default_nettype none
// channel   signals                                       dir
// config    cfg_valid cfg_ready target_sum                in
// input     in_valid in_ready single_power prefix_*       in
//           exponent minimum_base
// result    out_valid out_ready solved_base found         out
//
// one item at a time. exponent one: one division (64-step divider).
// search: floor-log2, four divisions, then per search step up to e
// rounds (a 64-bit multiply as four 32x32 steps, plus update) and one
// more round for the prefix terms.
// rst is synchronous and restores target_sum to 2. the result sits in an
// output register, so a new item is taken while it waits.
module aliquot_last_base_solver (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [als_pkg::FW-1:0] target_sum,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   single_power,
  input  wire logic [als_pkg::FW-1:0] prefix_sigma_in,
  input  wire logic [als_pkg::FW-1:0] prefix_aliquot_in,
  input  wire logic [als_pkg::EW-1:0] exponent,
  input  wire logic [als_pkg::FW-1:0] minimum_base,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [als_pkg::FW-1:0]      solved_base,
  output logic                        found
);

  als_pkg::cmd_t cmd;
  als_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  als_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  als_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .target_sum        (target_sum),
    .single_power      (single_power),
    .prefix_sigma_in   (prefix_sigma_in),
    .prefix_aliquot_in (prefix_aliquot_in),
    .exponent          (exponent),
    .minimum_base      (minimum_base),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .solved_base       (solved_base),
    .found             (found)
  );

endmodule
`default_nettype wire

>>> src/als_mul.sv
`default_nettype none
module als_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire als_pkg::sv_t  a,
  input  wire als_pkg::sv_t  b,
  output logic               busy,
  output als_pkg::sv_t       p
);

  logic [2*als_pkg::HW-1:0] ar;
  logic [2*als_pkg::HW-1:0] br;
  logic                     a_big;
  logic                     b_big;
  logic [4*als_pkg::HW-1:0] acc;
  logic [1:0]               step;
  logic [als_pkg::HW-1:0]   ah;
  logic [als_pkg::HW-1:0]   bh;
  logic [2*als_pkg::HW-1:0] pp;
  logic [4*als_pkg::HW-1:0] pp_sh;
  logic                     zero;

  assign ah = step[1] ? ar[2*als_pkg::HW-1:als_pkg::HW] : ar[als_pkg::HW-1:0];
  assign bh = step[0] ? br[2*als_pkg::HW-1:als_pkg::HW] : br[als_pkg::HW-1:0];
  assign pp = ah * bh;

  always_comb begin
    unique case (step)
      2'd0:    pp_sh = {{(2*als_pkg::HW){1'b0}}, pp};
      2'd3:    pp_sh = {pp, {(2*als_pkg::HW){1'b0}}};
      default: pp_sh = {{als_pkg::HW{1'b0}}, pp, {als_pkg::HW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar    <= (2*als_pkg::HW)'(a.v);
      br    <= (2*als_pkg::HW)'(b.v);
      a_big <= a.big;
      b_big <= b.big;
      acc   <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

  // a factor that is a true zero wins over saturation
  assign zero = (!a_big && ar == '0) || (!b_big && br == '0);

  always_comb begin
    if (zero) begin
      p.big = 1'b0;
      p.v   = '0;
    end else if (a_big || b_big || acc[4*als_pkg::HW-1:als_pkg::VW] != '0) begin
      p.big = 1'b1;
      p.v   = '1;
    end else begin
      p.big = 1'b0;
      p.v   = acc[als_pkg::VW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> src/als_div.sv
`default_nettype none
module als_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [als_pkg::VW-1:0] n,
  input  wire logic [als_pkg::VW-1:0] d,
  output logic                        busy,
  output logic [als_pkg::VW-1:0]      q,
  output logic [als_pkg::VW-1:0]      r
);

  logic [als_pkg::VW-1:0] dr;
  logic [als_pkg::CW-1:0] cnt;
  logic [als_pkg::VW:0]   trial;
  logic [als_pkg::VW:0]   shifted;

  assign shifted = {r, q[als_pkg::VW-1]};
  assign trial   = shifted - {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + als_pkg::CW'(1);
      if (cnt == als_pkg::CW'(als_pkg::VW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      q  <= n;
      r  <= '0;
      dr <= d;
    end else if (busy) begin
      if (!trial[als_pkg::VW]) begin
        r <= trial[als_pkg::VW-1:0];
        q <= {q[als_pkg::VW-2:0], 1'b1};
      end else begin
        r <= shifted[als_pkg::VW-1:0];
        q <= {q[als_pkg::VW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> src/als_dp.sv
`default_nettype none
module als_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire als_pkg::cmd_t          cmd,
  output als_pkg::sts_t               sts,
  input  wire logic                   cfg_valid,
  input  wire logic [als_pkg::FW-1:0] target_sum,
  input  wire logic                   single_power,
  input  wire logic [als_pkg::FW-1:0] prefix_sigma_in,
  input  wire logic [als_pkg::FW-1:0] prefix_aliquot_in,
  input  wire logic [als_pkg::EW-1:0] exponent,
  input  wire logic [als_pkg::FW-1:0] minimum_base,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [als_pkg::FW-1:0]      solved_base,
  output logic                        found
);

  localparam int VW = als_pkg::VW;
  localparam int SW = als_pkg::SW;
  localparam int LW = als_pkg::LW;
  localparam int EW = als_pkg::EW;

  logic [VW-1:0] tgt;
  logic          single;
  logic [VW-1:0] ps;
  logic [VW-1:0] pa;
  logic [EW-1:0] e;
  logic [VW-1:0] minb;

  logic [VW-1:0] xs, xa, xg;
  logic [LW-1:0] sl, al, sg;
  logic [SW-1:0] qa, qb, qc, qd;

  logic [VW-1:0] lo, hi, mid;
  als_pkg::sv_t  acc, pw, s;
  logic [EW-1:0] k;

  logic [SW-1:0] slw, alw, sgw, ew, n1, n2, m1, m2;
  logic [VW-1:0] dn, dd, dq, dr;
  logic          div_busy;

  als_pkg::sv_t  m0a, m0b, m1a, m1b, m0p, m1p, one_sv, s_cur;
  logic          mul0_busy, mul1_busy;

  logic [VW-1:0] lft_s, rgt_s, lft_p, rgt_p, lo_p;
  logic          cond_p;
  logic [VW-1:0] base;

  assign slw = SW'(sl);
  assign alw = SW'(al);
  assign sgw = SW'(sg);
  assign ew  = SW'(e);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt <= VW'(2);
    end else if (cfg_valid) begin
      tgt <= target_sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      single <= single_power;
      ps     <= prefix_sigma_in[VW-1:0];
      pa     <= prefix_aliquot_in[VW-1:0];
      e      <= exponent;
      minb   <= minimum_base[VW-1:0];
    end
  end

  // floor-log2 of target and both prefix values, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs <= tgt;
      xa <= prefix_aliquot_in[VW-1:0];
      xg <= prefix_sigma_in[VW-1:0];
      sl <= '0;
      al <= '0;
      sg <= '0;
    end else if (cmd.lg_step) begin
      if (xs > VW'(1)) begin
        xs <= xs >> 1;
        sl <= sl + LW'(1);
      end
      if (xa > VW'(1)) begin
        xa <= xa >> 1;
        al <= al + LW'(1);
      end
      if (xg > VW'(1)) begin
        xg <= xg >> 1;
        sg <= sg + LW'(1);
      end
    end
  end

  // bound exponent numerators, clamped at zero
  assign n1 = (slw + ew > alw) ? (slw + ew - alw) : '0;
  assign n2 = (slw + ew + SW'(1) > sgw) ? (slw + ew + SW'(1) - sgw) : '0;

  always_comb begin
    unique case (cmd.div_sel)
      als_pkg::SEL_E1: begin
        dn = tgt - ps;
        dd = pa;
      end
      als_pkg::SEL_A: begin
        dn = single ? VW'(slw - SW'(2)) : VW'(slw - alw - SW'(2));
        dd = single ? VW'(ew - SW'(1)) : VW'(ew);
      end
      als_pkg::SEL_B: begin
        dn = single ? VW'(slw + ew + SW'(1)) : VW'(slw - sgw - SW'(4));
        dd = VW'(ew - SW'(1));
      end
      als_pkg::SEL_C: begin
        dn = VW'(n1);
        dd = VW'(ew);
      end
      als_pkg::SEL_D: begin
        dn = VW'(n2);
        dd = VW'(ew - SW'(1));
      end
      default: begin
        dn = '0;
        dd = VW'(1);
      end
    endcase
  end

  als_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .n     (dn),
    .d     (dd),
    .busy  (div_busy),
    .q     (dq),
    .r     (dr)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        als_pkg::SEL_A: qa <= dq[SW-1:0];
        als_pkg::SEL_B: qb <= dq[SW-1:0];
        als_pkg::SEL_C: qc <= dq[SW-1:0];
        als_pkg::SEL_D: qd <= dq[SW-1:0];
        default: ;
      endcase
    end
  end

  // search bounds
  assign m1 = (qb < qa) ? qb : qa;
  assign m2 = (qd < qc) ? qd : qc;

  assign lft_s = (slw > (ew << 1)) ? (VW'(1) << (qa - SW'(1))) : VW'(2);
  assign rgt_s = (SW'(3) * (ew - SW'(2)) < (slw << 1)) ? als_pkg::rfl(qb) : VW'(2);

  assign cond_p = (slw >= alw + ((ew - SW'(1)) << 1)) &&
                  (slw >= sgw + ((ew + SW'(1)) << 1));
  assign lft_p  = (cond_p && m1 >= SW'(2)) ? (VW'(1) << (m1 - SW'(1))) : VW'(2);
  assign rgt_p  = als_pkg::rfl(m2);
  assign lo_p   = ((lft_p + VW'(1)) < minb) ? minb : (lft_p + VW'(1));

  // two multipliers: power and series in step, then the two prefix terms
  always_comb begin
    if (cmd.mul_fin) begin
      m0a = '{big: 1'b0, v: pa};
      m0b = pw;
      m1a = '{big: 1'b0, v: ps};
      m1b = acc;
    end else begin
      m0a = pw;
      m0b = '{big: 1'b0, v: mid};
      m1a = acc;
      m1b = '{big: 1'b0, v: mid};
    end
  end

  als_mul u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (m0a),
    .b     (m0b),
    .busy  (mul0_busy),
    .p     (m0p)
  );

  als_mul u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (m1a),
    .b     (m1b),
    .busy  (mul1_busy),
    .p     (m1p)
  );

  assign one_sv = '{big: 1'b0, v: VW'(1)};

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      lo <= single ? (lft_s + VW'(1)) : lo_p;
      hi <= single ? rgt_s : rgt_p;
    end else if (cmd.cmp_upd) begin
      if (sts.hit || (!s_cur.big && s_cur.v < tgt)) begin
        lo <= mid + VW'(1);
      end else begin
        hi <= mid - VW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_init) begin
      mid <= lo + ((hi - lo) >> 1);
      acc <= one_sv;
      pw  <= one_sv;
      k   <= '0;
    end else if (cmd.iter_upd) begin
      pw <= m0p;
      if ({1'b0, k} + (EW+1)'(1) < {1'b0, e}) begin
        acc <= als_pkg::sat_add(m1p, one_sv);
      end
      k <= k + EW'(1);
    end
    if (cmd.sum) begin
      s <= als_pkg::sat_add(m0p, m1p);
    end
  end

  assign s_cur = single ? acc : s;

  // result register
  always_comb begin
    unique case (cmd.res_sel)
      als_pkg::RES_E1:  base = (dr == '0 && dq >= VW'(2)) ? dq : '0;
      als_pkg::RES_MID: base = mid;
      default:          base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      solved_base <= als_pkg::FW'(base);
      found       <= (base != '0);
    end
  end

  always_comb begin
    sts.trivial     = (tgt < VW'(2)) || (e == '0) || (e > EW'(als_pkg::MAX_EXP)) ||
                      (single && e == EW'(1));
    sts.is_e1       = !single && e == EW'(1);
    sts.e1_ok       = (tgt > ps) && (pa != '0);
    sts.single      = single;
    sts.lg_done     = (xs <= VW'(1)) && (xa <= VW'(1)) && (xg <= VW'(1));
    sts.div_busy    = div_busy;
    sts.mul_busy    = mul0_busy || mul1_busy;
    sts.range_empty = lo > hi;
    sts.iter_last   = ({1'b0, k} + (EW+1)'(1) == {1'b0, e}) || (m0p.big && m1p.big);
    sts.hit         = !s_cur.big && s_cur.v == tgt;
    sts.stop        = (!s_cur.big && s_cur.v < tgt) ? (mid == hi)
                                                    : (mid == '0 || mid == lo);
    sts.out_busy    = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

>>> src/als_ctrl.sv
`default_nettype none
module als_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire als_pkg::sts_t sts,
  output als_pkg::cmd_t      cmd
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_CHECK     = 16'h0002,
    S_E1_WAIT   = 16'h0004,
    S_LG        = 16'h0008,
    S_DIV       = 16'h0010,
    S_DIV_WAIT  = 16'h0020,
    S_BOUNDS    = 16'h0040,
    S_RANGE     = 16'h0080,
    S_MUL       = 16'h0100,
    S_MUL_WAIT  = 16'h0200,
    S_ITER      = 16'h0400,
    S_FMUL      = 16'h0800,
    S_FMUL_WAIT = 16'h1000,
    S_SUM       = 16'h2000,
    S_CMP       = 16'h4000,
    S_FIN       = 16'h8000
  } state_t;

  state_t         state, state_next;
  als_pkg::sel_t  sel, sel_next;
  als_pkg::res_t  res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= als_pkg::SEL_A;
      res   <= als_pkg::RES_NONE;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      res   <= res_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    res_next    = res;
    cmd         = '0;
    cmd.div_sel = sel;
    cmd.res_sel = res;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        res_next = als_pkg::RES_NONE;
        if (sts.trivial) begin
          state_next = S_FIN;
        end else if (sts.is_e1) begin
          if (sts.e1_ok) begin
            cmd.div_sel   = als_pkg::SEL_E1;
            cmd.div_start = 1'b1;
            state_next    = S_E1_WAIT;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_LG;
        end
      end
      S_E1_WAIT: begin
        if (!sts.div_busy) begin
          res_next   = als_pkg::RES_E1;
          state_next = S_FIN;
        end
      end
      S_LG: begin
        cmd.lg_step = 1'b1;
        if (sts.lg_done) begin
          sel_next   = als_pkg::SEL_A;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          cmd.div_store = 1'b1;
          state_next    = S_DIV;
          unique case (sel)
            als_pkg::SEL_A: sel_next = als_pkg::SEL_B;
            als_pkg::SEL_B: sel_next = als_pkg::SEL_C;
            als_pkg::SEL_C: sel_next = als_pkg::SEL_D;
            default:        state_next = S_BOUNDS;
          endcase
        end
      end
      S_BOUNDS: begin
        cmd.bounds = 1'b1;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        if (sts.range_empty) begin
          res_next   = als_pkg::RES_NONE;
          state_next = S_FIN;
        end else begin
          cmd.eval_init = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (!sts.mul_busy) begin
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        cmd.iter_upd = 1'b1;
        if (sts.iter_last) begin
          state_next = sts.single ? S_CMP : S_FMUL;
        end else begin
          state_next = S_MUL;
        end
      end
      S_FMUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_fin   = 1'b1;
        state_next    = S_FMUL_WAIT;
      end
      S_FMUL_WAIT: begin
        if (!sts.mul_busy) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.hit) begin
          res_next   = als_pkg::RES_MID;
          state_next = S_FIN;
        end else if (sts.stop) begin
          res_next   = als_pkg::RES_NONE;
          state_next = S_FIN;
        end else begin
          cmd.cmp_upd = 1'b1;
          state_next  = S_RANGE;
        end
      end
      S_FIN: begin
        // wait for the output register to be free
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
